// ===== rtl/core/exp_golomb_bit_reader_macros.svh =====
// Assertion macros shared by the bit reader RTL.
// Relies on clk and rst_n being in scope where a macro is used.
`ifndef EXP_GOLOMB_BIT_READER_MACROS_SVH
`define EXP_GOLOMB_BIT_READER_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define EGBR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define EGBR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/egbr_pkg.sv =====
// Shared types and constants of the Exp-Golomb bit reader.
// No dependencies; used by egbr_step and exp_golomb_bit_reader.
`timescale 1ns / 1ps

package egbr_pkg;

  localparam int FUNC_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 6;
  localparam int VALUE_W = 32;
  localparam int SVAL_W  = 16;
  localparam int STAT_W  = 2;

  // Longest ue prefix accepted, and the widths that follow from it.
  localparam int MAX_PREFIX = 15;
  localparam int LZ_W       = 5;
  localparam int CODE_W     = 2 * MAX_PREFIX + 1;
  localparam int PEEK_W     = MAX_PREFIX + 1;

  localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FIXED = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_UE   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_SE   = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_END      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_TOO_LONG = 2'd2;
  localparam logic [STAT_W-1:0] STAT_DROPPED  = 2'd3;

  localparam logic [CNT_W-1:0] MAX_FIXED = 6'd32;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] byte_in;
    logic [CNT_W-1:0]  bit_count;
  } egbr_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]       value;
    logic signed [SVAL_W-1:0] signed_value;
    logic [STAT_W-1:0]        status;
  } egbr_result_t;

endpackage

// ===== rtl/core/egbr_step.sv =====
// Combinational step logic: push, fixed read, ue and se decode on the buffer.
// Depends on egbr_pkg.
`timescale 1ns / 1ps

module egbr_step #(
  parameter int BUFFER_BITS = 64
) (
  input  egbr_pkg::egbr_item_t            item,
  input  logic [BUFFER_BITS-1:0]          buf_cur,
  input  logic [$clog2(BUFFER_BITS+1)-1:0] fill_cur,
  output logic [BUFFER_BITS-1:0]          buf_nxt,
  output logic [$clog2(BUFFER_BITS+1)-1:0] fill_nxt,
  output egbr_pkg::egbr_result_t          result
);

  localparam int VW = $clog2(BUFFER_BITS + 1);

  logic [egbr_pkg::CNT_W-1:0]     cnt_sat;
  logic [egbr_pkg::VALUE_W-1:0]   top32;
  logic [egbr_pkg::VALUE_W-1:0]   fixed_val;
  logic [egbr_pkg::PEEK_W-1:0]    top16;
  logic [egbr_pkg::CODE_W-1:0]    top31;
  logic [egbr_pkg::LZ_W-1:0]      lz;
  logic [egbr_pkg::LZ_W-1:0]      zc;
  logic [egbr_pkg::LZ_W-1:0]      ue_len;
  logic [egbr_pkg::CODE_W-1:0]    code;
  logic [egbr_pkg::CODE_W-1:0]    k;
  logic [egbr_pkg::SVAL_W-1:0]    k16;
  logic [egbr_pkg::SVAL_W-1:0]    se_val;
  logic [VW:0]                    push_end;
  logic [BUFFER_BITS-1:0]         push_bits;

  assign top32 = buf_cur[BUFFER_BITS-1 -: egbr_pkg::VALUE_W];
  assign top16 = buf_cur[BUFFER_BITS-1 -: egbr_pkg::PEEK_W];
  assign top31 = buf_cur[BUFFER_BITS-1 -: egbr_pkg::CODE_W];

  assign cnt_sat   = (item.bit_count > egbr_pkg::MAX_FIXED) ? egbr_pkg::MAX_FIXED
                                                            : item.bit_count;
  assign fixed_val = top32 >> (egbr_pkg::MAX_FIXED - cnt_sat);

  assign push_end  = (VW+1)'(fill_cur) + (VW+1)'(egbr_pkg::BYTE_W);
  assign push_bits = {item.byte_in, {(BUFFER_BITS-egbr_pkg::BYTE_W){1'b0}}} >> fill_cur;

  // Leading zeros of the front 16 bits; the highest set bit wins.
  always_comb begin
    lz = egbr_pkg::LZ_W'(egbr_pkg::PEEK_W);
    for (int i = 0; i < egbr_pkg::PEEK_W; i++) begin
      if (top16[i]) begin
        lz = egbr_pkg::LZ_W'(egbr_pkg::PEEK_W - 1 - i);
      end
    end
  end

  // Prefix cannot run past the valid bits.
  assign zc     = (VW'(lz) > fill_cur) ? egbr_pkg::LZ_W'(fill_cur) : lz;
  assign ue_len = {zc[egbr_pkg::LZ_W-2:0], 1'b1};
  // Code word with its leading one sits at the bottom of the shifted peek.
  assign code   = top31 >> (egbr_pkg::LZ_W'(egbr_pkg::CODE_W - 1) -
                            {zc[egbr_pkg::LZ_W-2:0], 1'b0});
  assign k      = code - egbr_pkg::CODE_W'(1);
  assign k16    = k[egbr_pkg::SVAL_W-1:0];
  assign se_val = k16[0] ? egbr_pkg::SVAL_W'((17'(k16) + 17'd1) >> 1)
                         : egbr_pkg::SVAL_W'(17'd0 - (17'(k16) >> 1));

  always_comb begin
    buf_nxt             = buf_cur;
    fill_nxt            = fill_cur;
    result.value        = '0;
    result.signed_value = '0;
    result.status       = egbr_pkg::STAT_OK;
    unique case (item.func)
      egbr_pkg::FUNC_PUSH: begin
        if (push_end > (VW+1)'(BUFFER_BITS)) begin
          result.status = egbr_pkg::STAT_DROPPED;
        end else begin
          buf_nxt  = buf_cur | push_bits;
          fill_nxt = push_end[VW-1:0];
        end
      end
      egbr_pkg::FUNC_FIXED: begin
        if (VW'(cnt_sat) > fill_cur) begin
          result.status = egbr_pkg::STAT_END;
          result.value  = '1;
        end else begin
          result.value = fixed_val;
          buf_nxt      = buf_cur << cnt_sat;
          fill_nxt     = fill_cur - VW'(cnt_sat);
        end
      end
      egbr_pkg::FUNC_UE, egbr_pkg::FUNC_SE: begin
        if (zc > egbr_pkg::LZ_W'(egbr_pkg::MAX_PREFIX)) begin
          result.status = egbr_pkg::STAT_TOO_LONG;
          result.value  = '1;
        end else if (VW'(ue_len) > fill_cur) begin
          result.status = egbr_pkg::STAT_END;
          result.value  = '1;
        end else begin
          result.value = egbr_pkg::VALUE_W'(k);
          if (item.func == egbr_pkg::FUNC_SE) begin
            result.signed_value = se_val;
          end
          buf_nxt  = buf_cur << ue_len;
          fill_nxt = fill_cur - VW'(ue_len);
        end
      end
      default: begin
        result.status = egbr_pkg::STAT_OK;
      end
    endcase
  end

endmodule

// ===== rtl/core/exp_golomb_bit_reader.sv =====
// Top level of the MSB-first Exp-Golomb bit reader: handshakes and state.
// Depends on egbr_pkg, egbr_step and exp_golomb_bit_reader_macros.svh.
`timescale 1ns / 1ps

// Each input beat either pushes one stream byte into a left-aligned bit buffer
// of BUFFER_BITS bits or reads one field from its front: a fixed-length field
// of up to 32 bits (wider counts saturate to 32), an unsigned Exp-Golomb
// code, or a signed one. Every beat yields exactly one result beat, in order.
// A read that lacks bits reports end of data, returns all ones and consumes
// nothing, so it can be retried after more pushes; a ue/se prefix of 16 or
// more zeros reports code too long; a push into a buffer without room for
// eight more bits is dropped and flagged. The block takes one beat per clock
// while results are taken; each beat is held in the input register, from
// which the whole step (leading-zero count over 16 bits plus one barrel
// shift of the buffer) runs combinationally into the result register. A
// result that is not taken holds both registers, so at most two beats are
// in flight before in_ready drops.
// The next beat sees the buffer left by the previous one with no bubble.

`include "exp_golomb_bit_reader_macros.svh"

module exp_golomb_bit_reader #(
  parameter int BUFFER_BITS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [egbr_pkg::FUNC_W-1:0]        in_func,
  input  logic [egbr_pkg::BYTE_W-1:0]        in_byte_in,
  input  logic [egbr_pkg::CNT_W-1:0]         in_bit_count,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [egbr_pkg::VALUE_W-1:0]       out_value,
  output logic signed [egbr_pkg::SVAL_W-1:0] out_signed_value,
  output logic [egbr_pkg::STAT_W-1:0]        out_status
);

  localparam int VW = $clog2(BUFFER_BITS + 1);

  logic                   in_vld_r;
  egbr_pkg::egbr_item_t   item_r;
  logic                   out_vld_r;
  egbr_pkg::egbr_result_t result_r;
  egbr_pkg::egbr_result_t result_nxt;
  logic [BUFFER_BITS-1:0] bit_buffer_r;
  logic [BUFFER_BITS-1:0] bit_buffer_nxt;
  logic [VW-1:0]          valid_bits_r;
  logic [VW-1:0]          valid_bits_nxt;
  logic                   fire;

  // Check-only views of the state and results.
  logic [BUFFER_BITS-1:0]    tail_bits;
  logic [VW+BUFFER_BITS-1:0] buf_state;
  logic                      out_err;
  logic                      step_err;

  // Advance the held beat whenever the result register is free or draining.
  assign fire     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || fire;

  egbr_step #(
    .BUFFER_BITS(BUFFER_BITS)
  ) u_step (
    .item     (item_r),
    .buf_cur  (bit_buffer_r),
    .fill_cur (valid_bits_r),
    .buf_nxt  (bit_buffer_nxt),
    .fill_nxt (valid_bits_nxt),
    .result   (result_nxt)
  );

  // Input register: hold the beat until the step logic takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.func      <= in_func;
      item_r.byte_in   <= in_byte_in;
      item_r.bit_count <= in_bit_count;
    end
  end

  // Buffer state: advance only when a beat is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_buffer_r <= '0;
      valid_bits_r <= '0;
    end else if (fire) begin
      bit_buffer_r <= bit_buffer_nxt;
      valid_bits_r <= valid_bits_nxt;
    end
  end

  // Result register: hold until the consumer takes the beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_value        = result_r.value;
  assign out_signed_value = result_r.signed_value;
  assign out_status       = result_r.status;

  assign tail_bits = bit_buffer_r << valid_bits_r;
  assign buf_state = {valid_bits_r, bit_buffer_r};
  assign out_err   = out_vld_r && (out_status == egbr_pkg::STAT_END ||
                                   out_status == egbr_pkg::STAT_TOO_LONG);
  assign step_err  = fire && (result_nxt.status != egbr_pkg::STAT_OK);

  `EGBR_ASSERT_NOW(a_fill_bound, 1'b1, valid_bits_r <= VW'(BUFFER_BITS), "fill count overran")
  `EGBR_ASSERT_NOW(a_tail_clear, 1'b1, tail_bits == '0, "stale bits behind the fill point")
  `EGBR_ASSERT_NOW(a_err_ones, out_err, out_value == '1, "read error without all-ones value")
  `EGBR_ASSERT_NEXT(a_err_keeps, step_err, $stable(buf_state), "failed beat changed the buffer")

endmodule
